@@ rtl/undirected_cycle_finder_unit_defines.svh @@
// Assertion macros for the undirected cycle finder.
// Used by the RTL files that carry assertions; expects clk_i and rst_ni in scope.
`ifndef UNDIRECTED_CYCLE_FINDER_UNIT_DEFINES_SVH
`define UNDIRECTED_CYCLE_FINDER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define UCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define UCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  `UCF_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define UCF_ASSERT(lbl, prop, msg)
`define UCF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/ucf_pkg.sv @@
// Shared types and constants of the undirected cycle finder.
// No dependencies; used by the interfaces, controller, datapath and top level.
package ucf_pkg;

  localparam int VW = 11;  // vertex id, position and length width

  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic [2:0] ADDR_VCOUNT = 3'd0;

  typedef enum logic [4:0] {
    OP_NONE, OP_INIT, OP_LOAD, OP_DISP,
    OP_ERA, OP_EWA, OP_ERB, OP_EWB, OP_ELB,
    OP_CLR, OP_ROOT, OP_RCHK, OP_RHEAD, OP_TOP, OP_POP, OP_EDGE, OP_VIS, OP_PUSH,
    OP_CSTART, OP_CCHK, OP_CRD, OP_FIN
  } op_e;

  typedef struct packed {
    op_e  op;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       edge_bad;
    logic       edge_full;
    logic       cnt_last;
    logic       root_stop;
    logic       vis_rd;
    logic       it_end;
    logic       depth_one;
    logic       v_bad;
    logic       depth_full;
    logic       flag;
    logic       chain_go;
  } sts_t;

endpackage

@@ rtl/ucf_if.sv @@
// Valid/ready channel interfaces for items and results of the cycle finder.
// Depends on ucf_pkg for field widths.
interface ucf_in_if;
  import ucf_pkg::*;
  logic          valid;
  logic          ready;
  logic [1:0]    mode;
  logic [VW-1:0] end_a;
  logic [VW-1:0] end_b;
  logic [VW-1:0] position;
  modport source (output valid, mode, end_a, end_b, position, input ready);
  modport sink (input valid, mode, end_a, end_b, position, output ready);
endinterface

interface ucf_out_if;
  import ucf_pkg::*;
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic          found;
  logic [VW-1:0] cycle_length;
  logic [VW-1:0] vertex;
  modport source (output valid, status, found, cycle_length, vertex, input ready);
  modport sink (input valid, status, found, cycle_length, vertex, output ready);
endinterface

@@ rtl/undirected_cycle_finder_unit.sv @@
// Undirected cycle finder, top level.
// Items arrive on in_i (mode, end_a, end_b, position); one result per item leaves on
// out_o (status, found, cycle_length, vertex). Both are valid/ready channels; a
// transaction moves at a clock edge with valid and ready high.
// vertex_count sits at APB byte address 0; write it only while the block is idle.
// After reset the list heads are swept clear: in_i.ready stays low until the
// sweep is done.
// One item at a time: an add edge item reads and writes both adjacency lists, read
// items and bad items go straight to the result; the next item is taken once the
// result is loaded into the output register. A run first sweeps the visit marks, then
// walks the half-edges and vertices, then traces the cycle vertex by vertex; its time is
// set by the single read port of each memory.
// The result sits in an output register; a stalled receiver holds it there while the
// next item is accepted, and that item's result waits until the register is taken.
// Depends on ucf_pkg, ucf_if, ucf_ctrl and ucf_datapath.
module undirected_cycle_finder_unit #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ucf_in_if.sink      in_i,
  ucf_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ucf_pkg::*;

  logic [VW-1:0] vcount_q;
  cmd_t          cmd;
  sts_t          sts;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_VCOUNT) ? {{(32 - VW){1'b0}}, vcount_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VW'(1);
    end else if (psel && penable && pwrite && (paddr == ADDR_VCOUNT)) begin
      vcount_q <= pwdata[VW-1:0];
    end
  end

  ucf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ucf_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (in_i.mode),
    .end_a_i        (in_i.end_a),
    .end_b_i        (in_i.end_b),
    .position_i     (in_i.position),
    .vcount_i       (vcount_q),
    .status_o       (out_o.status),
    .found_o        (out_o.found),
    .cycle_length_o (out_o.cycle_length),
    .vertex_o       (out_o.vertex)
  );

endmodule

@@ rtl/ucf_ctrl.sv @@
// Sequencer of the cycle finder: one-hot state machine issuing datapath commands.
// Depends on ucf_pkg (cmd_t, sts_t, mode codes).
module ucf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ucf_pkg::sts_t sts_i,
  output ucf_pkg::cmd_t cmd_o
);
  import ucf_pkg::*;

  typedef enum logic [20:0] {
    S_INIT   = 21'h000001, S_IDLE  = 21'h000002, S_DISP  = 21'h000004,
    S_ERA    = 21'h000008, S_EWA   = 21'h000010, S_ERB   = 21'h000020,
    S_EWB    = 21'h000040, S_ELB   = 21'h000080, S_CLR   = 21'h000100,
    S_ROOT   = 21'h000200, S_RCHK  = 21'h000400, S_RHEAD = 21'h000800,
    S_TOP    = 21'h001000, S_POP   = 21'h002000, S_EDGE  = 21'h004000,
    S_VIS    = 21'h008000, S_PUSH  = 21'h010000, S_CSTART = 21'h020000,
    S_CCHK   = 21'h040000, S_CRD   = 21'h080000, S_FIN   = 21'h100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d         = state_q;
    cmd_o.op        = OP_NONE;
    cmd_o.load_out  = 1'b0;
    out_valid_d     = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_INIT: begin
        cmd_o.op = OP_INIT;
        if (sts_i.cnt_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        cmd_o.op = OP_DISP;
        unique case (sts_i.mode)
          MODE_ADD: state_d = (sts_i.edge_bad || sts_i.edge_full) ? S_FIN : S_ERA;
          MODE_RUN: state_d = S_CLR;
          default:  state_d = S_FIN;
        endcase
      end
      S_ERA: begin cmd_o.op = OP_ERA; state_d = S_EWA; end
      S_EWA: begin cmd_o.op = OP_EWA; state_d = S_ERB; end
      S_ERB: begin cmd_o.op = OP_ERB; state_d = S_EWB; end
      S_EWB: begin cmd_o.op = OP_EWB; state_d = S_ELB; end
      S_ELB: begin cmd_o.op = OP_ELB; state_d = S_FIN; end
      S_CLR: begin
        cmd_o.op = OP_CLR;
        if (sts_i.cnt_last) state_d = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.op = OP_ROOT;
        state_d  = sts_i.root_stop ? S_CSTART : S_RCHK;
      end
      S_RCHK: begin
        cmd_o.op = OP_RCHK;
        state_d  = sts_i.vis_rd ? S_ROOT : S_RHEAD;
      end
      S_RHEAD: begin cmd_o.op = OP_RHEAD; state_d = S_TOP; end
      S_TOP: begin
        cmd_o.op = OP_TOP;
        if (sts_i.it_end) state_d = sts_i.depth_one ? S_ROOT : S_POP;
        else              state_d = S_EDGE;
      end
      S_POP: begin cmd_o.op = OP_POP; state_d = S_TOP; end
      S_EDGE: begin
        cmd_o.op = OP_EDGE;
        state_d  = sts_i.v_bad ? S_TOP : S_VIS;
      end
      S_VIS: begin
        cmd_o.op = OP_VIS;
        state_d  = (!sts_i.vis_rd && !sts_i.depth_full) ? S_PUSH : S_TOP;
      end
      S_PUSH: begin cmd_o.op = OP_PUSH; state_d = S_TOP; end
      S_CSTART: begin
        cmd_o.op = OP_CSTART;
        state_d  = sts_i.flag ? S_CCHK : S_FIN;
      end
      S_CCHK: begin
        cmd_o.op = OP_CCHK;
        state_d  = sts_i.chain_go ? S_CRD : S_FIN;
      end
      S_CRD: begin cmd_o.op = OP_CRD; state_d = S_CCHK; end
      S_FIN: begin
        cmd_o.op = OP_FIN;
        // hold the result until the output register frees up
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/ucf_datapath.sv @@
// Datapath of the cycle finder: adjacency lists, walk stack, marks and cycle buffer.
// Depends on ucf_pkg and the assertion macros header; driven by ucf_ctrl commands.
`include "undirected_cycle_finder_unit_defines.svh"
module ucf_datapath #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ucf_pkg::cmd_t          cmd_i,
  output ucf_pkg::sts_t          sts_o,
  input  logic [1:0]             mode_i,
  input  logic [ucf_pkg::VW-1:0] end_a_i,
  input  logic [ucf_pkg::VW-1:0] end_b_i,
  input  logic [ucf_pkg::VW-1:0] position_i,
  input  logic [ucf_pkg::VW-1:0] vcount_i,
  output logic [1:0]             status_o,
  output logic                   found_o,
  output logic [ucf_pkg::VW-1:0] cycle_length_o,
  output logic [ucf_pkg::VW-1:0] vertex_o
);
  import ucf_pkg::*;

  localparam int HALF_CAP = 2 * MAX_EDGES;
  localparam int HW  = $clog2(HALF_CAP + 1);
  localparam int HAW = $clog2(HALF_CAP);
  localparam int VD  = MAX_VERTICES + 1;
  localparam int VIW = $clog2(VD);
  localparam int DW  = $clog2(MAX_VERTICES + 2);
  localparam int SW  = VW + HW;
  localparam logic [HW-1:0] NO_LINK = HW'(HALF_CAP);

  // item and control registers
  logic [1:0]    mode_q, status_q;
  logic [VW-1:0] a_q, b_q, pos_q;
  logic [HW-1:0] hcount_q, it_q;
  logic [VIW-1:0] cnt_q;
  logic [VW-1:0] r_q, u_q, v_q, i_q, start_q, end_q, len_q;
  logic [DW-1:0] depth_q, n_q;
  logic          flag_q, empty_q;
  logic [HAW-1:0] told_q;

  // memory ports
  logic [VW-1:0]  nbr_mem [HALF_CAP];
  logic [HW-1:0]  link_mem [HALF_CAP];
  logic [HW-1:0]  head_mem [VD];
  logic [HAW-1:0] tail_mem [VD];
  logic           vis_mem [VD];
  logic [VW-1:0]  par_mem [VD];
  logic [SW-1:0]  stk_mem [VD];
  logic [VW-1:0]  buf_mem [VD];

  logic           nbr_we, link_we, head_we, tail_we, vis_we, par_we, stk_we, buf_we;
  logic [HAW-1:0] nbr_wa, link_wa, hmem_ra;
  logic [VIW-1:0] head_wa, head_ra, tail_wa, tail_ra, vis_wa, vis_ra;
  logic [VIW-1:0] par_wa, par_ra, stk_wa, stk_ra, buf_wa, buf_ra;
  logic [VW-1:0]  nbr_wd, par_wd, buf_wd;
  logic [HW-1:0]  link_wd, head_wd;
  logic [HAW-1:0] tail_wd;
  logic           vis_wd;
  logic [SW-1:0]  stk_wd;
  logic [VW-1:0]  nbr_rd, par_rd, buf_rd;
  logic [HW-1:0]  link_rd, head_rd;
  logic [HAW-1:0] tail_rd;
  logic           vis_rd;
  logic [SW-1:0]  stk_rd;

  logic chain_go;

  assign chain_go = (i_q != start_q) && (i_q != '0) && (i_q <= MAX_VERTICES) &&
                    (n_q < MAX_VERTICES);

  always_comb begin
    sts_o.mode       = mode_q;
    sts_o.edge_bad   = (a_q == '0) || (a_q > MAX_VERTICES) ||
                       (b_q == '0) || (b_q > MAX_VERTICES);
    sts_o.edge_full  = (int'(hcount_q) + 2) > HALF_CAP;
    sts_o.cnt_last   = (cnt_q == VIW'(MAX_VERTICES));
    sts_o.root_stop  = flag_q || (r_q > vcount_i) || (r_q > MAX_VERTICES);
    sts_o.vis_rd     = vis_rd;
    sts_o.it_end     = (it_q >= NO_LINK);
    sts_o.depth_one  = (depth_q == DW'(1));
    sts_o.v_bad      = (nbr_rd == '0) || (nbr_rd > MAX_VERTICES);
    sts_o.depth_full = (depth_q > MAX_VERTICES);
    sts_o.flag       = flag_q;
    sts_o.chain_go   = chain_go;
  end

  // memory port steering
  always_comb begin
    nbr_we = 1'b0; link_we = 1'b0; head_we = 1'b0; tail_we = 1'b0;
    vis_we = 1'b0; par_we = 1'b0; stk_we = 1'b0; buf_we = 1'b0;
    nbr_wa = hcount_q[HAW-1:0]; link_wa = hcount_q[HAW-1:0];
    hmem_ra = it_q[HAW-1:0];
    head_wa = VIW'(a_q); head_ra = VIW'(a_q); tail_wa = VIW'(a_q); tail_ra = VIW'(a_q);
    vis_wa = VIW'(r_q); vis_ra = VIW'(r_q); par_wa = VIW'(v_q); par_ra = VIW'(u_q);
    stk_wa = VIW'(depth_q - DW'(1)); stk_ra = VIW'(depth_q - DW'(2));
    buf_wa = VIW'(n_q); buf_ra = VIW'(pos_q);
    nbr_wd = b_q; link_wd = NO_LINK; head_wd = hcount_q; tail_wd = hcount_q[HAW-1:0];
    vis_wd = 1'b1; par_wd = u_q; stk_wd = {u_q, it_q}; buf_wd = start_q;
    case (cmd_i.op)
      OP_INIT: begin
        head_we = 1'b1;
        head_wa = cnt_q;
        head_wd = NO_LINK;
      end
      OP_EWA, OP_EWB: begin
        nbr_we  = 1'b1;
        nbr_wd  = (cmd_i.op == OP_EWA) ? b_q : a_q;
        link_we = 1'b1;
        tail_we = 1'b1;
        tail_wa = (cmd_i.op == OP_EWA) ? VIW'(a_q) : VIW'(b_q);
        head_we = (head_rd == NO_LINK);
        head_wa = tail_wa;
      end
      OP_ERB, OP_ELB: begin
        // chain the previous tail to the half-edge just written
        link_we = !empty_q;
        link_wa = told_q;
        link_wd = hcount_q;
        head_ra = VIW'(b_q);
        tail_ra = VIW'(b_q);
      end
      OP_CLR: begin
        vis_we = 1'b1; vis_wa = cnt_q; vis_wd = 1'b0;
        par_we = 1'b1; par_wa = cnt_q; par_wd = '0;
      end
      OP_RCHK: begin
        vis_we  = !vis_rd;
        head_ra = VIW'(r_q);
      end
      OP_EDGE: begin
        vis_ra = VIW'(nbr_rd);
      end
      OP_VIS: begin
        if (!vis_rd && !sts_o.depth_full) begin
          par_we = 1'b1;
          vis_we = 1'b1;
          vis_wa = VIW'(v_q);
          stk_we = 1'b1;
        end
        head_ra = VIW'(v_q);
      end
      OP_CSTART: begin
        buf_we = flag_q;
        buf_wa = '0;
      end
      OP_CCHK: begin
        buf_we = 1'b1;
        buf_wd = chain_go ? i_q : start_q;
        par_ra = VIW'(i_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (nbr_we) nbr_mem[nbr_wa] <= nbr_wd;
    nbr_rd <= nbr_mem[hmem_ra];
  end
  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd <= link_mem[hmem_ra];
  end
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd <= head_mem[head_ra];
  end
  always_ff @(posedge clk_i) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    tail_rd <= tail_mem[tail_ra];
  end
  always_ff @(posedge clk_i) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_rd <= vis_mem[vis_ra];
  end
  always_ff @(posedge clk_i) begin
    if (par_we) par_mem[par_wa] <= par_wd;
    par_rd <= par_mem[par_ra];
  end
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd <= stk_mem[stk_ra];
  end
  always_ff @(posedge clk_i) begin
    if (buf_we) buf_mem[buf_wa] <= buf_wd;
    buf_rd <= buf_mem[buf_ra];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcount_q <= '0;
      cnt_q    <= '0;
      depth_q  <= '0;
      flag_q   <= 1'b0;
      start_q  <= '0;
      end_q    <= '0;
      len_q    <= '0;
    end else begin
      case (cmd_i.op)
        OP_INIT, OP_CLR: cnt_q <= cnt_q + VIW'(1);
        OP_DISP: begin
          if (mode_q == MODE_RUN) begin
            cnt_q   <= '0;
            flag_q  <= 1'b0;
            start_q <= '0;
            end_q   <= '0;
            len_q   <= '0;
          end
        end
        OP_ERB, OP_ELB: hcount_q <= hcount_q + HW'(1);
        OP_RHEAD: depth_q <= DW'(1);
        OP_TOP: if (it_q >= NO_LINK) depth_q <= depth_q - DW'(1);
        OP_PUSH: depth_q <= depth_q + DW'(1);
        OP_VIS: begin
          if (vis_rd && (par_rd != v_q)) begin
            start_q <= u_q;
            end_q   <= v_q;
            flag_q  <= 1'b1;
          end
        end
        OP_CCHK: if (!chain_go) len_q <= VW'(n_q + DW'(1));
        default: ;
      endcase
    end
  end

  // walk and item registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        mode_q <= mode_i;
        a_q    <= end_a_i;
        b_q    <= end_b_i;
        pos_q  <= position_i;
      end
      OP_DISP: begin
        r_q <= VW'(1);
        unique case (mode_q)
          MODE_ADD: begin
            if (sts_o.edge_bad)       status_q <= ST_BAD;
            else if (sts_o.edge_full) status_q <= ST_FULL;
            else                      status_q <= ST_OK;
          end
          MODE_RUN:  status_q <= ST_OK;
          MODE_READ: status_q <= (pos_q < len_q) ? ST_OK : ST_BAD;
          default:   status_q <= ST_BAD;
        endcase
      end
      OP_EWA, OP_EWB: begin
        empty_q <= (head_rd == NO_LINK);
        told_q  <= tail_rd;
      end
      OP_RCHK: if (vis_rd) r_q <= r_q + VW'(1);
      OP_RHEAD: begin
        u_q  <= r_q;
        it_q <= head_rd;
      end
      OP_TOP: if ((it_q >= NO_LINK) && (depth_q == DW'(1))) r_q <= r_q + VW'(1);
      OP_POP: {u_q, it_q} <= stk_rd;
      OP_EDGE: begin
        v_q  <= nbr_rd;
        it_q <= link_rd;
      end
      OP_PUSH: begin
        u_q  <= v_q;
        it_q <= head_rd;
      end
      OP_CSTART: begin
        n_q <= DW'(1);
        i_q <= end_q;
      end
      OP_CCHK: if (chain_go) n_q <= n_q + DW'(1);
      OP_CRD: i_q <= par_rd;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_o       <= status_q;
      found_o        <= flag_q;
      cycle_length_o <= len_q;
      vertex_o       <= ((mode_q == MODE_READ) && (status_q == ST_OK)) ? buf_rd : '0;
    end
  end

  `UCF_ASSERT(a_hcount_cap, hcount_q <= NO_LINK, "half-edge count beyond capacity")
  `UCF_ASSERT(a_top_nonempty, (cmd_i.op == OP_TOP) |-> (depth_q != '0), "walk on empty stack")
  `UCF_ASSERT_NEXT(a_push_depth, cmd_i.op == OP_PUSH, depth_q == $past(depth_q) + DW'(1), "push lost")
  `UCF_ASSERT(a_chain_len, (cmd_i.op == OP_CCHK) |-> (n_q <= MAX_VERTICES), "cycle buffer overrun")

endmodule
